// ----- hdl/cfd_pkg.sv -----
`timescale 1ns / 1ps
package cfd_pkg;

    // coordinate width that covers the largest screen side, and a signed
    // width that holds every sum of two 16-bit fields without wrapping
    localparam int COORD_W     = 11;
    localparam int WIDE_W      = 18;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] REQ_PIXEL   = 3'd0;
    localparam logic [2:0] REQ_HLINE   = 3'd1;
    localparam logic [2:0] REQ_VLINE   = 3'd2;
    localparam logic [2:0] REQ_OUTLINE = 3'd3;
    localparam logic [2:0] REQ_FILLED  = 3'd4;
    localparam logic [2:0] REQ_FILL    = 3'd5;
    localparam logic [2:0] REQ_READ    = 3'd6;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] span_w;
        logic signed [15:0] span_h;
        logic [7:0]         pixel_color;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       nothing_drawn;
    } result_t;

    typedef enum logic [1:0] {
        JOB_SKIP,
        JOB_DRAW,
        JOB_READ
    } job_op_t;

    // one clipped box, half-open in both directions
    typedef struct packed {
        job_op_t            op;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] y1;
        logic [7:0]         color;
        logic               last;
        logic               any;
    } job_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_SETUP,
        B_FILL,
        B_RADDR,
        B_RDATA,
        B_RESP
    } back_state_t;

    typedef struct packed {
        logic               nonempty;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
    } clip_t;

    // clip [lo, hi) to [0, limit)
    function automatic clip_t clip_span(input logic signed [WIDE_W-1:0] lo,
                                        input logic signed [WIDE_W-1:0] hi,
                                        input logic signed [WIDE_W-1:0] limit);
        logic signed [WIDE_W-1:0] lo_c;
        logic signed [WIDE_W-1:0] hi_c;
        clip_t                    r;
        lo_c       = (lo < $signed({WIDE_W{1'b0}})) ? '0 : lo;
        hi_c       = (hi > limit) ? limit : hi;
        r.nonempty = hi_c > lo_c;
        r.lo       = lo_c[COORD_W-1:0];
        r.hi       = hi_c[COORD_W-1:0];
        return r;
    endfunction

endpackage

// ----- hdl/cfd_front.sv -----
`timescale 1ns / 1ps
module cfd_front
    import cfd_pkg::*;
#(
    parameter int SCREEN_COLS = 240,
    parameter int SCREEN_ROWS = 160
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic job_valid,
    input  logic job_ready,
    output job_t job
);

    logic                     busy_reg;
    logic [1:0]               idx_reg;
    logic                     any_reg;
    logic [2:0]               kind_reg;
    logic [7:0]               color_reg;
    logic signed [WIDE_W-1:0] x_reg;
    logic signed [WIDE_W-1:0] y_reg;
    logic signed [WIDE_W-1:0] x1p_reg;
    logic signed [WIDE_W-1:0] y1p_reg;
    logic signed [WIDE_W-1:0] xw_reg;
    logic signed [WIDE_W-1:0] xw1_reg;
    logic signed [WIDE_W-1:0] yh_reg;
    logic signed [WIDE_W-1:0] yh1_reg;

    logic signed [WIDE_W-1:0] lo_x;
    logic signed [WIDE_W-1:0] hi_x;
    logic signed [WIDE_W-1:0] lo_y;
    logic signed [WIDE_W-1:0] hi_y;
    logic                     last;
    logic                     is_read;
    logic                     is_none;
    clip_t                    cx;
    clip_t                    cy;
    logic                     ne;

    assign in_ready  = !busy_reg;
    assign job_valid = busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
            any_reg  <= 1'b0;
        end else if (in_valid && in_ready) begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
            any_reg  <= 1'b0;
        end else if (job_valid && job_ready) begin
            busy_reg <= !last;
            idx_reg  <= idx_reg + 2'd1;
            any_reg  <= any_reg | ne;
        end
    end

    // edge sums taken once per command
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            kind_reg  <= in_cmd.req_type;
            color_reg <= in_cmd.pixel_color;
            x_reg     <= WIDE_W'(in_cmd.pos_x);
            y_reg     <= WIDE_W'(in_cmd.pos_y);
            x1p_reg   <= WIDE_W'(in_cmd.pos_x) + WIDE_W'(1);
            y1p_reg   <= WIDE_W'(in_cmd.pos_y) + WIDE_W'(1);
            xw_reg    <= WIDE_W'(in_cmd.pos_x) + WIDE_W'(in_cmd.span_w);
            xw1_reg   <= WIDE_W'(in_cmd.pos_x) + WIDE_W'(in_cmd.span_w) - WIDE_W'(1);
            yh_reg    <= WIDE_W'(in_cmd.pos_y) + WIDE_W'(in_cmd.span_h);
            yh1_reg   <= WIDE_W'(in_cmd.pos_y) + WIDE_W'(in_cmd.span_h) - WIDE_W'(1);
        end
    end

    // box selection per command kind
    always_comb begin
        lo_x    = x_reg;
        hi_x    = x1p_reg;
        lo_y    = y_reg;
        hi_y    = y1p_reg;
        last    = 1'b1;
        is_read = 1'b0;
        is_none = 1'b0;
        case (kind_reg)
            REQ_PIXEL: begin
            end
            REQ_HLINE: begin
                hi_x = xw_reg;
            end
            REQ_VLINE: begin
                hi_y = yh_reg;
            end
            REQ_OUTLINE: begin
                last = (idx_reg == 2'd3);
                case (idx_reg)
                    2'd0: begin
                        hi_x = xw_reg;
                    end
                    2'd1: begin
                        hi_x = xw_reg;
                        lo_y = yh1_reg;
                        hi_y = yh_reg;
                    end
                    2'd2: begin
                        lo_y = y1p_reg;
                        hi_y = yh1_reg;
                    end
                    default: begin
                        lo_x = xw1_reg;
                        hi_x = xw_reg;
                        lo_y = y1p_reg;
                        hi_y = yh1_reg;
                    end
                endcase
            end
            REQ_FILLED: begin
                hi_x = xw_reg;
                hi_y = yh_reg;
            end
            REQ_FILL: begin
                lo_x = '0;
                hi_x = WIDE_W'(SCREEN_COLS);
                lo_y = '0;
                hi_y = WIDE_W'(SCREEN_ROWS);
            end
            REQ_READ: begin
                is_read = 1'b1;
            end
            default: begin
                is_none = 1'b1;
            end
        endcase
    end

    assign cx = clip_span(lo_x, hi_x, WIDE_W'(SCREEN_COLS));
    assign cy = clip_span(lo_y, hi_y, WIDE_W'(SCREEN_ROWS));
    assign ne = cx.nonempty && cy.nonempty && !is_none;

    always_comb begin
        job.x0    = cx.lo;
        job.x1    = cx.hi;
        job.y0    = cy.lo;
        job.y1    = cy.hi;
        job.color = color_reg;
        job.last  = last;
        if (is_read) begin
            job.op  = ne ? JOB_READ : JOB_SKIP;
            job.any = ne;
        end else begin
            job.op  = ne ? JOB_DRAW : JOB_SKIP;
            job.any = any_reg | ne;
        end
    end

endmodule

// ----- hdl/cfd_queue.sv -----
`timescale 1ns / 1ps
module cfd_queue
    import cfd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t          entries_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != (PW+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (PW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

// ----- hdl/cfd_back.sv -----
`timescale 1ns / 1ps
module cfd_back
    import cfd_pkg::*;
#(
    parameter int SCREEN_COLS = 240,
    parameter int SCREEN_ROWS = 160
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    job_valid,
    output logic    job_ready,
    input  job_t    job,
    output logic    clearing,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    localparam int DEPTH = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]         mem [DEPTH];
    logic [7:0]         mem_q;

    back_state_t        state_reg;
    back_state_t        state_next;
    job_t               job_reg;
    logic [AW-1:0]      base_reg;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic [AW-1:0]      clr_reg;
    logic [7:0]         rd_reg;
    logic               res_valid_reg;
    result_t            res_reg;

    logic               col_end;
    logic               row_end;
    logic [AW-1:0]      pix_addr;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [7:0]         mem_wdata;
    logic               res_load;

    assign col_end  = (col_reg == job_reg.x1 - COORD_W'(1));
    assign row_end  = (row_reg == job_reg.y1 - COORD_W'(1));
    assign pix_addr = base_reg + AW'(col_reg);
    assign clearing = (state_reg == B_CLEAR);
    assign m_valid  = res_valid_reg;
    assign m_data   = res_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR: begin
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (job_valid) begin
                    if (job.op inside {JOB_DRAW, JOB_READ}) begin
                        state_next = B_SETUP;
                    end else if (job.last) begin
                        state_next = B_RESP;
                    end
                end
            end
            B_SETUP: begin
                state_next = (job_reg.op == JOB_READ) ? B_RADDR : B_FILL;
            end
            B_FILL: begin
                if (col_end && row_end) begin
                    state_next = job_reg.last ? B_RESP : B_IDLE;
                end
            end
            B_RADDR: begin
                state_next = B_RDATA;
            end
            B_RDATA: begin
                state_next = B_RESP;
            end
            B_RESP: begin
                if (!res_valid_reg || m_ready) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb begin
        job_ready = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = pix_addr;
        mem_wdata = job_reg.color;
        res_load  = 1'b0;
        case (state_reg)
            B_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            B_IDLE: begin
                job_ready = 1'b1;
            end
            B_FILL: begin
                mem_we = 1'b1;
            end
            B_RESP: begin
                res_load = !res_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (res_load) begin
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_valid && job_ready) begin
            job_reg <= job;
            rd_reg  <= '0;
        end
        if (state_reg == B_SETUP) begin
            col_reg  <= job_reg.x0;
            row_reg  <= job_reg.y0;
            base_reg <= AW'(job_reg.y0) * AW'(SCREEN_COLS);
        end
        if (state_reg == B_FILL) begin
            if (col_end) begin
                col_reg  <= job_reg.x0;
                row_reg  <= row_reg + COORD_W'(1);
                base_reg <= base_reg + AW'(SCREEN_COLS);
            end else begin
                col_reg <= col_reg + COORD_W'(1);
            end
        end
        if (state_reg == B_RDATA) begin
            rd_reg <= mem_q;
        end
        if (res_load) begin
            res_reg.read_data     <= rd_reg;
            res_reg.nothing_drawn <= !job_reg.any;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[pix_addr];
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && !m_ready |=> res_valid_reg && $stable(res_reg))
        else $error("pending result changed before transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_RESP |-> job_reg.last)
        else $error("result raised on a box that is not the last of its command");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_FILL |->
            (col_reg >= job_reg.x0) && (col_reg < job_reg.x1) && (row_reg < job_reg.y1))
        else $error("fill walk left its clipped box");

endmodule

// ----- hdl/clipped_framebuffer_draw.sv -----
`timescale 1ns / 1ps
// channel  | ports                    | payload  | transfer when
// ---------+--------------------------+----------+----------------------
// command  | s_valid, s_ready, s_data | cmd_t    | s_valid && s_ready
// result   | m_valid, m_ready, m_data | result_t | m_valid && m_ready
//
// reset: the store's SCREEN_COLS * SCREEN_ROWS pixels (38400 by default) are cleared one pixel a cycle
// with s_ready low
// front: one clipped box a cycle while the queue has room (four for an outline); a box is formed from the
// registered command and reaches the back end through a four-entry queue
// back: takes a box in B_IDLE, then a drawn box goes through B_SETUP and B_FILL, one pixel a cycle;
// B_RESP loads the result (a read first goes through B_SETUP, B_RADDR and B_RDATA); a waiting result stalls s_ready
// once the queue and the front are full
module clipped_framebuffer_draw
    import cfd_pkg::*;
#(
    parameter int SCREEN_COLS = 240,
    parameter int SCREEN_ROWS = 160
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  cmd_t    s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    // front end: holds one command and emits its clipped boxes
    logic front_ready;
    logic clearing;

    // queue of clipped boxes between front and back
    logic fq_valid;
    logic fq_ready;
    job_t fq_job;
    logic qb_valid;
    logic qb_ready;
    job_t qb_job;

    // no command transfer while the store is being cleared
    assign s_ready = front_ready && !clearing;

    cfd_front #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && !clearing),
        .in_ready  (front_ready),
        .in_cmd    (s_data),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    cfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_job   (qb_job)
    );

    // back end: walks each box over the frame store and holds the result
    cfd_back #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .clearing  (clearing),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
